>>> sv/llsd_pkg.sv
// ----------------------------------------------------------------------------
// llsd_pkg
// Shared types and constants of the least-loaded server dispatcher.
// ----------------------------------------------------------------------------
package llsd_pkg;

    // operation codes carried in tuser
    localparam logic [1:0] OP_LOAD     = 2'd0;
    localparam logic [1:0] OP_DISPATCH = 2'd1;
    localparam logic [1:0] OP_CLEAR    = 2'd2;

    // servers that the 4-bit server index can reach
    localparam int unsigned IDX_LIMIT = 16;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_LAST,
        ST_RATE,
        ST_MUL,
        ST_ADD,
        ST_WRITE,
        ST_DONE
    } t_state;

    // controls of the shared arithmetic unit
    typedef struct packed {
        logic mul_en;
        logic add_en;
    } t_alu_ctl;

endpackage

>>> sv/least_loaded_server_dispatch.sv
// ----------------------------------------------------------------------------
// least_loaded_server_dispatch
// Least-loaded list scheduler: picks the earliest-free server for each job.
// ----------------------------------------------------------------------------
// Each input transfer carries an operation in tuser: load a server rate
// (which also clears that server's finish time), dispatch a job, or clear all
// finish times and the makespan. One result transfer follows every input.
// A dispatch walks the finish-time RAM one entry per cycle over the n active
// servers (n = server_count clamped to 1..min(SERVERS,16)), keeping the
// lowest-index minimum, then reads the chosen rate, multiplies, adds with
// saturation and writes back. Loads, clears and the unused code go straight
// to the result state. The block takes one item at a time and accepts the
// next while the last result waits in the output register. Reset clears all
// rates and finish times at once through per-entry valid bits; no clearing
// pass is needed.
module least_loaded_server_dispatch
    import llsd_pkg::*;
#(
    parameter int SERVERS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [4:0]  i_cfg_data,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // [3:0] server_index, [11:4] service_rate, [19:12] item_count, [23:20] zero
    input  logic [23:0] s_axis_tdata,
    // [1:0] operation
    input  logic [1:0]  s_axis_tuser,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [3:0] chosen_server, [35:4] finish_time, [67:36] makespan, [71:68] zero
    output logic [71:0] m_axis_tdata
);

    localparam int DEPTH = (SERVERS < IDX_LIMIT) ? SERVERS : IDX_LIMIT;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW    = $clog2(DEPTH + 1);

    t_state r_state, n_state;

    logic [4:0]    r_server_count;
    logic [CW-1:0] r_n;
    logic [CW-1:0] r_cnt;
    logic [1:0]    r_op;
    logic [7:0]    r_items;
    logic          r_pend;
    logic [AW-1:0] r_pend_idx;
    logic          r_fval_q;
    logic          r_rval_q;
    logic [DEPTH-1:0] r_fvalid;
    logic [DEPTH-1:0] r_rvalid;
    logic [31:0]   r_best;
    logic [AW-1:0] r_chosen;
    logic [31:0]   r_fin;
    logic [31:0]   r_max;
    logic          r_out_valid;
    logic [71:0]   r_out_data;

    logic          accept;
    logic [1:0]    in_op;
    logic [3:0]    in_idx;
    logic [7:0]    in_rate;
    logic [7:0]    in_items;
    logic          load_hit;
    logic [4:0]    cnt_clamp;
    logic          last_issue;
    logic          out_load;
    logic          f_we;
    logic [AW-1:0] f_raddr;
    logic [31:0]   f_rdata;
    logic [31:0]   f_val;
    logic [AW-1:0] rt_raddr;
    logic [7:0]    rt_rdata;
    logic [7:0]    rt_val;
    logic          take;
    logic          alu_less;
    logic [31:0]   alu_sum;
    t_alu_ctl      alu_ctl;

    assign in_op    = s_axis_tuser;
    assign in_idx   = s_axis_tdata[3:0];
    assign in_rate  = s_axis_tdata[11:4];
    assign in_items = s_axis_tdata[19:12];
    assign accept   = s_axis_tvalid && s_axis_tready;
    assign load_hit = (32'(in_idx) < 32'(DEPTH));

    always_comb begin
        if (r_server_count == 5'd0) begin
            cnt_clamp = 5'd1;
        end else if (r_server_count > 5'(DEPTH)) begin
            cnt_clamp = 5'(DEPTH);
        end else begin
            cnt_clamp = r_server_count;
        end
    end

    assign last_issue = (r_cnt == r_n - CW'(1));
    assign out_load   = (r_state == ST_DONE) && (!r_out_valid || m_axis_tready);

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    n_state = (in_op == OP_DISPATCH) ? ST_SCAN : ST_DONE;
                end
            end
            ST_SCAN: begin
                if (last_issue) begin
                    n_state = ST_LAST;
                end
            end
            ST_LAST:  n_state = ST_RATE;
            ST_RATE:  n_state = ST_MUL;
            ST_MUL:   n_state = ST_ADD;
            ST_ADD:   n_state = ST_WRITE;
            ST_WRITE: n_state = ST_DONE;
            ST_DONE: begin
                if (out_load) begin
                    n_state = ST_IDLE;
                end
            end
            default:  n_state = ST_IDLE;
        endcase
    end

    // outputs of the sequencer
    always_comb begin
        s_axis_tready  = 1'b0;
        alu_ctl.mul_en = 1'b0;
        alu_ctl.add_en = 1'b0;
        f_we           = 1'b0;
        f_raddr        = r_chosen;
        case (r_state)
            ST_IDLE:  s_axis_tready  = 1'b1;
            ST_SCAN:  f_raddr        = r_cnt[AW-1:0];
            ST_MUL:   alu_ctl.mul_en = 1'b1;
            ST_ADD:   alu_ctl.add_en = 1'b1;
            ST_WRITE: f_we           = 1'b1;
            default: begin
            end
        endcase
    end

    assign rt_raddr = r_chosen;
    assign f_val    = r_fval_q ? f_rdata : 32'd0;
    assign rt_val   = r_rval_q ? rt_rdata : 8'd0;
    assign take     = r_pend && ((r_pend_idx == '0) || alu_less);

    llsd_ram #(
        .WIDTH (32),
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_finish_ram (
        .i_clk   (i_clk),
        .i_we    (f_we),
        .i_waddr (r_chosen),
        .i_wdata (alu_sum),
        .i_raddr (f_raddr),
        .o_rdata (f_rdata)
    );

    llsd_ram #(
        .WIDTH (8),
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_rate_ram (
        .i_clk   (i_clk),
        .i_we    (accept && (in_op == OP_LOAD) && load_hit),
        .i_waddr (in_idx[AW-1:0]),
        .i_wdata (in_rate),
        .i_raddr (rt_raddr),
        .o_rdata (rt_rdata)
    );

    llsd_alu u_alu (
        .i_clk   (i_clk),
        .i_ctl   (alu_ctl),
        .i_cmp_a (f_val),
        .i_cmp_b (r_best),
        .i_rate  (rt_val),
        .i_items (r_items),
        .i_base  (r_best),
        .o_less  (alu_less),
        .o_sum   (alu_sum)
    );

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= ST_IDLE;
            r_server_count <= 5'd1;
            r_fvalid       <= '0;
            r_rvalid       <= '0;
            r_max          <= 32'd0;
            r_out_valid    <= 1'b0;
            r_pend         <= 1'b0;
            r_cnt          <= '0;
        end else begin
            r_state <= n_state;
            r_pend  <= (r_state == ST_SCAN);
            if (i_cfg_we) begin
                r_server_count <= i_cfg_data;
            end
            if (r_state == ST_SCAN) begin
                r_cnt <= r_cnt + CW'(1);
            end else begin
                r_cnt <= '0;
            end
            if (accept && (in_op == OP_LOAD) && load_hit) begin
                r_rvalid[in_idx[AW-1:0]] <= 1'b1;
                r_fvalid[in_idx[AW-1:0]] <= 1'b0;
            end
            if (accept && (in_op == OP_CLEAR)) begin
                r_fvalid <= '0;
                r_max    <= 32'd0;
            end
            if (f_we) begin
                r_fvalid[r_chosen] <= 1'b1;
                if (alu_sum > r_max) begin
                    r_max <= alu_sum;
                end
            end
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        r_fval_q   <= r_fvalid[f_raddr];
        r_rval_q   <= r_rvalid[rt_raddr];
        r_pend_idx <= r_cnt[AW-1:0];
        if (accept) begin
            r_op     <= in_op;
            r_items  <= in_items;
            r_n      <= CW'(cnt_clamp);
            r_chosen <= '0;
            r_fin    <= 32'd0;
        end
        if (take) begin
            r_best   <= f_val;
            r_chosen <= r_pend_idx;
        end
        if (f_we) begin
            r_fin <= alu_sum;
        end
        if (out_load) begin
            r_out_data <= {4'd0, r_max, r_fin,
                           (r_op == OP_DISPATCH) ? 4'(r_chosen) : 4'd0};
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

endmodule

>>> sv/llsd_ram.sv
// ----------------------------------------------------------------------------
// llsd_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module llsd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> sv/llsd_alu.sv
// ----------------------------------------------------------------------------
// llsd_alu
// Shared compare and multiply-add unit: finish-time compare during the scan,
// registered rate x items product, then a registered saturating add.
// ----------------------------------------------------------------------------
module llsd_alu
    import llsd_pkg::*;
(
    input  logic        i_clk,
    input  t_alu_ctl    i_ctl,
    input  logic [31:0] i_cmp_a,
    input  logic [31:0] i_cmp_b,
    input  logic [7:0]  i_rate,
    input  logic [7:0]  i_items,
    input  logic [31:0] i_base,
    output logic        o_less,
    output logic [31:0] o_sum
);

    logic [15:0] r_prod;
    logic [31:0] r_sum;
    logic [32:0] sum_wide;

    assign o_less   = (i_cmp_a < i_cmp_b);
    assign sum_wide = {1'b0, i_base} + {17'd0, r_prod};

    always_ff @(posedge i_clk) begin
        if (i_ctl.mul_en) begin
            r_prod <= 16'(i_rate) * 16'(i_items);
        end
        if (i_ctl.add_en) begin
            // hold at the top of the range on overflow
            r_sum <= sum_wide[32] ? 32'hFFFF_FFFF : sum_wide[31:0];
        end
    end

    assign o_sum = r_sum;

endmodule
